[rtl/core/alb_pkg.sv]
// alb_pkg: shared widths, register indexes, reset values and the window status type
// for the ambient light backlight dimmer. no dependencies.
package alb_pkg;

	localparam int REG_W = 12;
	localparam int LVL_W = 8;
	localparam int PCT_W = 7;
	localparam int SHF_W = 3;
	localparam int IDX_W = 3;
	localparam int SQ_W  = 2 * REG_W;
	localparam int NUM_W = SQ_W + LVL_W;

	localparam logic [IDX_W-1:0] REG_SENSOR_LOW   = 3'd0;
	localparam logic [IDX_W-1:0] REG_SENSOR_HIGH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MIN_LEVEL    = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_LEVEL    = 3'd3;
	localparam logic [IDX_W-1:0] REG_SMOOTH_SHIFT = 3'd4;
	localparam logic [IDX_W-1:0] REG_ACTIVE_HIGH  = 3'd5;
	localparam logic [IDX_W-1:0] REG_BL_ENABLED   = 3'd6;

	localparam logic [REG_W-1:0] SENSOR_LOW_RST   = 12'd200;
	localparam logic [REG_W-1:0] SENSOR_HIGH_RST  = 12'd2000;
	localparam logic [LVL_W-1:0] MIN_LEVEL_RST    = 8'd51;
	localparam logic [LVL_W-1:0] MAX_LEVEL_RST    = 8'd255;
	localparam logic [SHF_W-1:0] SMOOTH_SHIFT_RST = 3'd3;
	localparam logic [LVL_W-1:0] LEVEL_RST        = 8'd128;
	localparam logic [LVL_W-1:0] LEVEL_FULL       = 8'd255;

	typedef struct packed {
		logic done;
		logic full;
	} win_stat_t;

endpackage

[rtl/core/alb_window.sv]
// alb_window: circular sample window in a one-port memory with running sum,
// write slot and wrap flag; the old entry is read before it is overwritten. uses alb_pkg.
module alb_window #(
	parameter int DEPTH = 100,
	parameter int SAMPLE_BITS = 12,
	localparam int CNT_W = $clog2(DEPTH),
	localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [SAMPLE_BITS-1:0] sample,
	output alb_pkg::win_stat_t     stat,
	output logic [CNT_W-1:0]       slot,
	output logic [SUM_W-1:0]       sum
);

	logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
	logic [SAMPLE_BITS-1:0] old_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                   pend_q;
	logic                   full_q;
	logic [CNT_W-1:0]       slot_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       old_ext;

	// read old entry, then overwrite it
	always_ff @(posedge clk) begin
		if (go) begin
			old_q <= mem_q[slot_q];
			smp_q <= sample;
		end
		if (pend_q) begin
			mem_q[slot_q] <= smp_q;
		end
	end

	assign old_ext = full_q ? SUM_W'(old_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			full_q <= 1'b0;
			slot_q <= '0;
			sum_q  <= '0;
		end else begin
			pend_q <= go;
			if (pend_q) begin
				sum_q <= sum_q - old_ext + SUM_W'(smp_q);
				if (slot_q == CNT_W'(DEPTH - 1)) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	assign stat.done = pend_q;
	assign stat.full = full_q;
	assign slot      = slot_q;
	assign sum       = sum_q;

endmodule

[rtl/core/alb_sermul.sv]
// alb_sermul: bit-serial shift-add multiplier, one multiplier bit per cycle,
// msb first. no dependencies.
module alb_sermul #(
	parameter int A_W = 24,
	parameter int B_W = 12,
	localparam int P_W = A_W + B_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [P_W-1:0] prod
);

	localparam int CW = $clog2(B_W + 1);

	logic [A_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [P_W-1:0] acc_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : P_W'(0));
			b_q   <= {b_q[B_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(B_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/core/alb_serdiv.sv]
// alb_serdiv: bit-serial restoring divider, one quotient bit per cycle.
// divisor must be nonzero. no dependencies.
module alb_serdiv #(
	parameter int N_W = 32,
	parameter int D_W = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CW = $clog2(N_W + 1);

	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dvs_q;
	logic [N_W-1:0] quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [D_W:0]   shifted;
	logic [D_W+1:0] trial;
	logic           ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !trial[D_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(N_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/ambient_light_backlight_dimmer_unit.sv]
// ambient_light_backlight_dimmer_unit: top level, sequencer around the sample window, a
// serial multiplier and a serial divider. uses alb_pkg, alb_window, alb_sermul and alb_serdiv.
// each beat runs up to two serial divides and three serial multiplies; without a store
// the window write is skipped, and a divide is skipped for an empty window or low >= high;
// one item in flight, next beat taken in the cycle after the result loads
// reset (async, active low): registers to defaults, level 128, window empty, storage not cleared
module ambient_light_backlight_dimmer_unit #(
	parameter int WINDOW_DEPTH = 100,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [SAMPLE_BITS-1:0]           sensor_sample,
	input  logic                             store_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [alb_pkg::LVL_W-1:0]        level,
	output logic [alb_pkg::PCT_W-1:0]        level_percent,
	output logic [alb_pkg::LVL_W-1:0]        pwm_duty,
	output logic                             duty_valid,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [alb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [alb_pkg::REG_W-1:0]        cfg_data
);

	localparam int REG_W = alb_pkg::REG_W;
	localparam int LVL_W = alb_pkg::LVL_W;
	localparam int SQ_W  = alb_pkg::SQ_W;
	localparam int NUM_W = alb_pkg::NUM_W;
	localparam int CNT_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int CMP_W = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
	localparam int DVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int DVS_W = ((CNT_W + 1) > SQ_W) ? (CNT_W + 1) : SQ_W;
	localparam int MP_W  = SQ_W + REG_W;
	localparam int TGT_W = 17;
	localparam int DIF_W = TGT_W + 1;
	localparam int PX_W  = 15;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIN,
		ST_AVG,
		ST_ADIV,
		ST_CLAMP,
		ST_SQD,
		ST_SQS,
		ST_MULR,
		ST_QDIV,
		ST_LVL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [REG_W-1:0]         sensor_low_q;
	logic [REG_W-1:0]         sensor_high_q;
	logic [LVL_W-1:0]         min_level_q;
	logic [LVL_W-1:0]         max_level_q;
	logic [alb_pkg::SHF_W-1:0] smooth_shift_q;
	logic                     active_high_q;
	logic                     bl_enabled_q;

	logic [SAMPLE_BITS-1:0]   smp_q;
	logic [SAMPLE_BITS-1:0]   v_q;
	logic [REG_W-1:0]         span_q;
	logic [SQ_W-1:0]          d2_q;
	logic [SQ_W-1:0]          s2_q;
	logic [NUM_W-1:0]         q_q;
	logic [LVL_W-1:0]         cur_q;

	logic                     win_go_q;
	logic                     mul_go_q;
	logic [SQ_W-1:0]          mul_a_q;
	logic [REG_W-1:0]         mul_b_q;
	logic                     div_go_q;
	logic [DVD_W-1:0]         div_n_q;
	logic [DVS_W-1:0]         div_d_q;

	logic                     out_valid_q;
	logic [LVL_W-1:0]         level_q;
	logic [alb_pkg::PCT_W-1:0] pct_q;
	logic [LVL_W-1:0]         duty_q;
	logic                     duty_valid_q;

	alb_pkg::win_stat_t       win_stat;
	logic [CNT_W-1:0]         win_slot;
	logic [SUM_W-1:0]         win_sum;
	logic                     mul_done;
	logic [MP_W-1:0]          mul_p;
	logic                     div_done;
	logic [DVD_W-1:0]         div_q;

	logic [REG_W-1:0]         vc;
	logic [REG_W-1:0]         span;
	logic [REG_W-1:0]         dabs;
	logic [LVL_W-1:0]         range_pos;
	logic [LVL_W-1:0]         lvl_next;
	logic [alb_pkg::PCT_W-1:0] pct_next;
	logic [LVL_W-1:0]         duty_next;
	logic                     in_acc;

	alb_window #(
		.DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.go(win_go_q),
		.sample(smp_q),
		.stat(win_stat),
		.slot(win_slot),
		.sum(win_sum)
	);

	alb_sermul #(
		.A_W(SQ_W),
		.B_W(REG_W)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_go_q),
		.a(mul_a_q),
		.b(mul_b_q),
		.done(mul_done),
		.prod(mul_p)
	);

	alb_serdiv #(
		.N_W(DVD_W),
		.D_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_go_q),
		.dividend(div_n_q),
		.divisor(div_d_q),
		.done(div_done),
		.quotient(div_q)
	);

	// sensor clamp, offset magnitude and span
	always_comb begin
		logic [CMP_W-1:0] v_ext;
		logic [CMP_W-1:0] lo_ext;
		logic [CMP_W-1:0] hi_ext;
		logic [CMP_W-1:0] t1;
		logic [CMP_W-1:0] t2;
		logic [REG_W:0]   dsig;
		logic [REG_W:0]   dneg;
		v_ext  = CMP_W'(v_q);
		lo_ext = CMP_W'(sensor_low_q);
		hi_ext = CMP_W'(sensor_high_q);
		t1     = (v_ext < lo_ext) ? lo_ext : v_ext;
		t2     = (t1 > hi_ext) ? hi_ext : t1;
		vc     = t2[REG_W-1:0];
		dsig   = {1'b0, vc} - {1'b0, sensor_low_q};
		dneg   = (REG_W + 1)'(0) - dsig;
		dabs   = dsig[REG_W] ? dneg[REG_W-1:0] : dsig[REG_W-1:0];
		span   = (sensor_high_q > sensor_low_q) ? (sensor_high_q - sensor_low_q) :
			REG_W'(1);
	end

	assign range_pos = (max_level_q >= min_level_q) ? (max_level_q - min_level_q) : '0;

	// approach step and level clamp
	always_comb begin
		logic [TGT_W-1:0]        tgt;
		logic signed [DIF_W-1:0] diff;
		logic signed [DIF_W-1:0] step;
		logic signed [DIF_W-1:0] nxt;
		logic signed [DIF_W-1:0] lo_c;
		logic signed [DIF_W-1:0] hi_c;
		if (|q_q[NUM_W-1:16]) begin
			tgt = '1;
		end else begin
			tgt = TGT_W'(min_level_q) + TGT_W'(q_q[15:0]);
		end
		diff = $signed({1'b0, tgt}) - $signed(DIF_W'(cur_q));
		step = diff >>> smooth_shift_q;
		nxt  = $signed(DIF_W'(cur_q)) + step;
		lo_c = $signed(DIF_W'(min_level_q));
		hi_c = $signed(DIF_W'(max_level_q));
		if (nxt < lo_c) begin
			nxt = lo_c;
		end
		if (nxt > hi_c) begin
			nxt = hi_c;
		end
		lvl_next = nxt[LVL_W-1:0];
	end

	// percent as floor(x/255) with x = level*100
	always_comb begin
		logic [PX_W-1:0] x;
		logic [PX_W-1:0] t;
		x = {1'b0, cur_q, 6'b0} + {2'b0, cur_q, 5'b0} + {5'b0, cur_q, 2'b0};
		t = x + PX_W'(1) + (x >> 8);
		pct_next = t[PX_W-1:8];
	end

	always_comb begin
		if (!bl_enabled_q) begin
			duty_next = '0;
		end else if (active_high_q) begin
			duty_next = cur_q;
		end else begin
			duty_next = alb_pkg::LEVEL_FULL - cur_q;
		end
	end

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sensor_low_q   <= alb_pkg::SENSOR_LOW_RST;
			sensor_high_q  <= alb_pkg::SENSOR_HIGH_RST;
			min_level_q    <= alb_pkg::MIN_LEVEL_RST;
			max_level_q    <= alb_pkg::MAX_LEVEL_RST;
			smooth_shift_q <= alb_pkg::SMOOTH_SHIFT_RST;
			active_high_q  <= 1'b1;
			bl_enabled_q   <= 1'b1;
			cur_q          <= alb_pkg::LEVEL_RST;
			smp_q          <= '0;
			v_q            <= '0;
			span_q         <= '0;
			d2_q           <= '0;
			s2_q           <= '0;
			q_q            <= '0;
			win_go_q       <= 1'b0;
			mul_go_q       <= 1'b0;
			mul_a_q        <= '0;
			mul_b_q        <= '0;
			div_go_q       <= 1'b0;
			div_n_q        <= '0;
			div_d_q        <= '0;
			out_valid_q    <= 1'b0;
			level_q        <= '0;
			pct_q          <= '0;
			duty_q         <= '0;
			duty_valid_q   <= 1'b0;
		end else begin
			win_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					alb_pkg::REG_SENSOR_LOW:   sensor_low_q   <= cfg_data;
					alb_pkg::REG_SENSOR_HIGH:  sensor_high_q  <= cfg_data;
					alb_pkg::REG_MIN_LEVEL:    min_level_q    <= cfg_data[LVL_W-1:0];
					alb_pkg::REG_MAX_LEVEL:    max_level_q    <= cfg_data[LVL_W-1:0];
					alb_pkg::REG_SMOOTH_SHIFT: smooth_shift_q <= cfg_data[alb_pkg::SHF_W-1:0];
					alb_pkg::REG_ACTIVE_HIGH:  active_high_q  <= cfg_data[0];
					alb_pkg::REG_BL_ENABLED:   bl_enabled_q   <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						smp_q <= sensor_sample;
						if (store_sample) begin
							win_go_q <= 1'b1;
							state_q  <= ST_WIN;
						end else begin
							state_q <= ST_AVG;
						end
					end
				end
				ST_WIN: begin
					if (win_stat.done) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (win_stat.full || (win_slot != '0)) begin
						div_go_q <= 1'b1;
						div_n_q  <= DVD_W'(win_sum);
						div_d_q  <= win_stat.full ? DVS_W'(WINDOW_DEPTH) : DVS_W'(win_slot);
						state_q  <= ST_ADIV;
					end else begin
						v_q     <= smp_q;
						state_q <= ST_CLAMP;
					end
				end
				ST_ADIV: begin
					if (div_done) begin
						v_q     <= div_q[SAMPLE_BITS-1:0];
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					span_q   <= span;
					mul_go_q <= 1'b1;
					mul_a_q  <= SQ_W'(dabs);
					mul_b_q  <= dabs;
					state_q  <= ST_SQD;
				end
				ST_SQD: begin
					if (mul_done) begin
						d2_q     <= mul_p[SQ_W-1:0];
						mul_go_q <= 1'b1;
						mul_a_q  <= SQ_W'(span_q);
						mul_b_q  <= span_q;
						state_q  <= ST_SQS;
					end
				end
				ST_SQS: begin
					if (mul_done) begin
						s2_q     <= mul_p[SQ_W-1:0];
						mul_go_q <= 1'b1;
						mul_a_q  <= d2_q;
						mul_b_q  <= REG_W'(range_pos);
						state_q  <= ST_MULR;
					end
				end
				ST_MULR: begin
					if (mul_done) begin
						if (sensor_low_q < sensor_high_q) begin
							div_go_q <= 1'b1;
							div_n_q  <= DVD_W'(mul_p[NUM_W-1:0]);
							div_d_q  <= DVS_W'(s2_q);
							state_q  <= ST_QDIV;
						end else begin
							q_q     <= mul_p[NUM_W-1:0];
							state_q <= ST_LVL;
						end
					end
				end
				ST_QDIV: begin
					if (div_done) begin
						q_q     <= div_q[NUM_W-1:0];
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					cur_q   <= lvl_next;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						level_q      <= cur_q;
						pct_q        <= pct_next;
						duty_q       <= duty_next;
						duty_valid_q <= bl_enabled_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign level_percent = pct_q;
	assign pwm_duty      = duty_q;
	assign duty_valid    = duty_valid_q;

endmodule

[rtl/core/alb_checker.sv]
// alb_checker: port-level checks for ambient_light_backlight_dimmer_unit,
// attached by the bind at the end of this file. uses alb_pkg.
module alb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [alb_pkg::LVL_W-1:0]        level,
	input logic [alb_pkg::PCT_W-1:0]        level_percent,
	input logic [alb_pkg::LVL_W-1:0]        pwm_duty,
	input logic                             duty_valid
);

	// one item at a time
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat taken while busy");

	// result never appears the cycle after an input beat
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level) && $stable(pwm_duty))
		else $error("stalled result changed");

	a_duty_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !duty_valid |-> pwm_duty == '0)
		else $error("duty driven while backlight disabled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_percent <= 7'd100)
		else $error("percent out of range");

endmodule

bind ambient_light_backlight_dimmer_unit alb_checker u_alb_checker (.*);

[test/tb_ambient_light_backlight_dimmer_unit.sv]
// tb_ambient_light_backlight_dimmer_unit: directed table then random phases against a
// built-in brightness predictor, with random idling on both channels.
// depends on alb_pkg and ambient_light_backlight_dimmer_unit.
`timescale 1ns / 100ps

module tb_ambient_light_backlight_dimmer_unit;

	localparam int WIN_DEPTH = 100;
	localparam int SMP_BITS = 12;
	localparam logic [alb_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [alb_pkg::LVL_W-1:0] level;
		logic [alb_pkg::PCT_W-1:0] pct;
		logic [alb_pkg::LVL_W-1:0] duty;
		logic                      dv;
	} bright_t;

	typedef struct {
		bit                        is_cfg;
		logic [alb_pkg::IDX_W-1:0] idx;
		logic [11:0]               val;
		logic                      st;
		bit                        chk;
		bright_t                   exp;
	} step_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [SMP_BITS-1:0]       sensor_sample = '0;
	logic                      store_sample = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [alb_pkg::LVL_W-1:0] level;
	logic [alb_pkg::PCT_W-1:0] level_percent;
	logic [alb_pkg::LVL_W-1:0] pwm_duty;
	logic                      duty_valid;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [alb_pkg::IDX_W-1:0] cfg_index = '0;
	logic [alb_pkg::REG_W-1:0] cfg_data = '0;

	ambient_light_backlight_dimmer_unit #(
		.WINDOW_DEPTH(WIN_DEPTH),
		.SAMPLE_BITS(SMP_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sensor_sample(sensor_sample),
		.store_sample(store_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.level_percent(level_percent),
		.pwm_duty(pwm_duty),
		.duty_valid(duty_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of registers and window
	int cf_low = alb_pkg::SENSOR_LOW_RST;
	int cf_high = alb_pkg::SENSOR_HIGH_RST;
	int cf_min = alb_pkg::MIN_LEVEL_RST;
	int cf_max = alb_pkg::MAX_LEVEL_RST;
	int cf_shift = alb_pkg::SMOOTH_SHIFT_RST;
	int cf_act_hi = 1;
	int cf_bl_en = 1;

	logic [11:0] win_mem [WIN_DEPTH];
	int          win_slot = 0;
	bit          win_full = 1'b0;
	int          win_sum = 0;
	int          cur_lvl = alb_pkg::LEVEL_RST;

	bright_t pending_levels [$];
	step_t   script [$];
	int      fault_count = 0;
	bit      idle_on = 1'b1;
	int      stall_left = 0;

	function automatic bright_t predict_brightness(input logic [11:0] smp, input logic st);
		longint v, lo, hi, span, d, num, den, q, tgt, cur, diff;
		bright_t r;
		if (st) begin
			if (win_full)
				win_sum -= win_mem[win_slot];
			win_mem[win_slot] = smp;
			win_sum += smp;
			win_slot++;
			if (win_slot >= WIN_DEPTH) begin
				win_slot = 0;
				win_full = 1'b1;
			end
		end
		if (win_full)
			v = longint'(win_sum / WIN_DEPTH);
		else if (win_slot > 0)
			v = longint'(win_sum / win_slot);
		else
			v = longint'(smp);
		lo = cf_low;
		hi = cf_high;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		span = hi - lo;
		if (span < 1) span = 1;
		d = v - lo;
		num = d * d * (longint'(cf_max) - longint'(cf_min));
		den = span * span;
		q = num / den;
		if ((num % den != 0) && (num < 0))
			q -= 1;
		tgt = longint'(cf_min) + q;
		cur = cur_lvl;
		diff = tgt - cur;
		if (diff < 0)
			cur -= (-diff + (longint'(1) << cf_shift) - 1) >> cf_shift;
		else
			cur += diff >> cf_shift;
		if (cur < cf_min) cur = cf_min;
		if (cur > cf_max) cur = cf_max;
		cur_lvl = int'(cur) & 8'hFF;
		r.level = cur_lvl[7:0];
		r.pct = 7'((cur_lvl * 100) / 255);
		r.duty = cf_act_hi ? cur_lvl[7:0] : 8'(255 - cur_lvl);
		if (!cf_bl_en)
			r.duty = '0;
		r.dv = cf_bl_en[0];
		return r;
	endfunction

	function automatic void add_cfg(input logic [alb_pkg::IDX_W-1:0] idx,
			input logic [11:0] val);
		step_t s;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.val = val;
		s.st = 1'b0;
		s.chk = 1'b0;
		s.exp = '0;
		script.push_back(s);
	endfunction

	function automatic void add_beat(input logic [11:0] smp, input logic st);
		step_t s;
		s.is_cfg = 1'b0;
		s.idx = '0;
		s.val = smp;
		s.st = st;
		s.chk = 1'b0;
		s.exp = '0;
		script.push_back(s);
	endfunction

	function automatic void add_beat_chk(input logic [11:0] smp, input logic st,
			input int lv, input int pc, input int dt, input logic dv);
		step_t s;
		s.is_cfg = 1'b0;
		s.idx = '0;
		s.val = smp;
		s.st = st;
		s.chk = 1'b1;
		s.exp.level = lv[7:0];
		s.exp.pct = pc[6:0];
		s.exp.duty = dt[7:0];
		s.exp.dv = dv;
		script.push_back(s);
	endfunction

	task automatic write_reg(input logic [alb_pkg::IDX_W-1:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			alb_pkg::REG_SENSOR_LOW:   cf_low = val;
			alb_pkg::REG_SENSOR_HIGH:  cf_high = val;
			alb_pkg::REG_MIN_LEVEL:    cf_min = val[7:0];
			alb_pkg::REG_MAX_LEVEL:    cf_max = val[7:0];
			alb_pkg::REG_SMOOTH_SHIFT: cf_shift = val[2:0];
			alb_pkg::REG_ACTIVE_HIGH:  cf_act_hi = val[0];
			alb_pkg::REG_BL_ENABLED:   cf_bl_en = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_beat(input logic [11:0] smp, input logic st, input bit chk,
			input bright_t exp);
		bright_t pred;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 13)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sensor_sample <= smp;
		store_sample <= st;
		do @(posedge clk); while (in_stall);
		pred = predict_brightness(smp, st);
		pending_levels.push_back(chk ? exp : pred);
	endtask

	task automatic program_phase(input int mode);
		int lo, hi, mn, mx;
		case (mode)
			0: begin
				lo = alb_pkg::SENSOR_LOW_RST; hi = alb_pkg::SENSOR_HIGH_RST;
				mn = alb_pkg::MIN_LEVEL_RST; mx = alb_pkg::MAX_LEVEL_RST;
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, alb_pkg::SMOOTH_SHIFT_RST);
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 1);
				write_reg(alb_pkg::REG_BL_ENABLED, 1);
			end
			1: begin
				// raw 12-bit data everywhere, upper bits masked by the block
				lo = $urandom_range(0, 4095); hi = $urandom_range(0, 4095);
				mn = $urandom_range(0, 4095); mx = $urandom_range(0, 4095);
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, 12'($urandom_range(0, 4095)));
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 12'($urandom_range(0, 4095)));
				write_reg(alb_pkg::REG_BL_ENABLED, 12'($urandom_range(0, 4095) | 1));
			end
			2: begin
				lo = 0; hi = 4095; mn = 0; mx = alb_pkg::LEVEL_FULL;
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, 0);
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 12'($urandom_range(0, 1)));
				write_reg(alb_pkg::REG_BL_ENABLED, 1);
			end
			3: begin
				lo = $urandom_range(0, 4000); hi = lo + $urandom_range(0, 95);
				mn = $urandom_range(0, 100); mx = $urandom_range(150, 255);
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, 12'($urandom_range(0, 7)));
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 12'($urandom_range(0, 1)));
				write_reg(alb_pkg::REG_BL_ENABLED, 12'($urandom_range(0, 1)));
			end
			4: begin
				// low above high and max below min
				lo = $urandom_range(2048, 4095); hi = $urandom_range(0, 2047);
				mn = $urandom_range(128, 255); mx = $urandom_range(0, 127);
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, 7);
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 0);
				write_reg(alb_pkg::REG_BL_ENABLED, 1);
			end
			default: begin
				lo = 4095; hi = 4095; mn = alb_pkg::LEVEL_FULL; mx = alb_pkg::LEVEL_FULL;
				write_reg(alb_pkg::REG_SMOOTH_SHIFT, 7);
				write_reg(alb_pkg::REG_ACTIVE_HIGH, 0);
				write_reg(alb_pkg::REG_BL_ENABLED, 0);
			end
		endcase
		write_reg(alb_pkg::REG_SENSOR_LOW, 12'(lo));
		write_reg(alb_pkg::REG_SENSOR_HIGH, 12'(hi));
		write_reg(alb_pkg::REG_MIN_LEVEL, 12'(mn));
		write_reg(alb_pkg::REG_MAX_LEVEL, 12'(mx));
		write_reg(REG_UNUSED, 12'($urandom_range(0, 4095)));
	endtask

	always @(negedge clk) begin
		if (!idle_on) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		bright_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_levels.size() == 0) begin
				if (fault_count < 10)
					$display("unexpected beat: level %0d pct %0d duty %0d dv %0d",
						level, level_percent, pwm_duty, duty_valid);
				fault_count++;
			end else begin
				e = pending_levels.pop_front();
				if (level !== e.level || level_percent !== e.pct ||
						pwm_duty !== e.duty || duty_valid !== e.dv) begin
					if (fault_count < 10)
						$display("mismatch: level %0d/%0d pct %0d/%0d duty %0d/%0d dv %0d/%0d",
							e.level, level, e.pct, level_percent, e.duty, pwm_duty,
							e.dv, duty_valid);
					fault_count++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("ambient_light_backlight_dimmer_unit verification failed");
		$finish;
	end

	initial begin
		int phase_mode [8] = '{1, 2, 3, 4, 1, 5, 3, 0};
		int c;
		logic [11:0] smp;
		logic st;

		// after reset: raw sample path, default registers
		add_beat_chk(12'd0, 1'b0, 118, 46, 118, 1'b1);
		add_beat(12'd4095, 1'b0);
		add_beat(12'd2047, 1'b0);
		add_cfg(alb_pkg::REG_SENSOR_LOW, 0);
		add_cfg(alb_pkg::REG_SENSOR_HIGH, 4095);
		add_cfg(alb_pkg::REG_MIN_LEVEL, 0);
		add_cfg(alb_pkg::REG_MAX_LEVEL, 255);
		add_cfg(alb_pkg::REG_SMOOTH_SHIFT, 0);
		add_cfg(alb_pkg::REG_ACTIVE_HIGH, 1);
		add_cfg(alb_pkg::REG_BL_ENABLED, 1);
		add_beat_chk(12'd0, 1'b0, 0, 0, 0, 1'b1);
		add_beat_chk(12'd4095, 1'b0, 255, 100, 255, 1'b1);
		add_cfg(alb_pkg::REG_ACTIVE_HIGH, 0);
		add_beat_chk(12'd4095, 1'b0, 255, 100, 0, 1'b1);
		add_beat_chk(12'd0, 1'b0, 0, 0, 255, 1'b1);
		// backlight disabled
		add_cfg(alb_pkg::REG_BL_ENABLED, 0);
		add_beat_chk(12'd4095, 1'b0, 255, 100, 0, 1'b0);
		add_cfg(alb_pkg::REG_BL_ENABLED, 1);
		add_cfg(alb_pkg::REG_ACTIVE_HIGH, 1);
		add_beat_chk(12'd4095, 1'b1, 255, 100, 255, 1'b1);
		add_beat(12'd0, 1'b1);
		add_beat(12'd4095, 1'b1);
		add_beat(12'd0, 1'b1);
		// out of range index is ignored
		add_cfg(REG_UNUSED, 12'hFFF);
		add_beat(12'd0, 1'b0);
		// low above high
		add_cfg(alb_pkg::REG_SENSOR_LOW, 3000);
		add_cfg(alb_pkg::REG_SENSOR_HIGH, 1000);
		add_beat(12'd2000, 1'b1);
		// max below min
		add_cfg(alb_pkg::REG_SENSOR_LOW, 0);
		add_cfg(alb_pkg::REG_SENSOR_HIGH, 4095);
		add_cfg(alb_pkg::REG_MIN_LEVEL, 200);
		add_cfg(alb_pkg::REG_MAX_LEVEL, 50);
		add_beat(12'd4095, 1'b1);
		add_beat(12'd0, 1'b1);
		add_cfg(alb_pkg::REG_SMOOTH_SHIFT, 7);
		add_cfg(alb_pkg::REG_MIN_LEVEL, 0);
		add_cfg(alb_pkg::REG_MAX_LEVEL, 255);
		add_beat(12'd4095, 1'b1);
		add_beat(12'd0, 1'b1);
		// zero span
		add_cfg(alb_pkg::REG_SENSOR_LOW, 4095);
		add_cfg(alb_pkg::REG_SENSOR_HIGH, 4095);
		add_beat(12'd4095, 1'b1);
		add_beat(12'd0, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				wait_idle();
				write_reg(script[i].idx, script[i].val);
			end else begin
				send_beat(script[i].val, script[i].st, script[i].chk, script[i].exp);
			end
		end

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			program_phase(phase_mode[p]);
			@(posedge clk);
			idle_on = (p < 7);
			for (int n = 0; n < 112; n++) begin
				case ($urandom_range(0, 9))
					0: smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					1, 2: begin
						c = ($urandom_range(0, 1) ? cf_high : cf_low) + $urandom_range(0, 40) - 20;
						if (c < 0) c = 0;
						if (c > 4095) c = 4095;
						smp = 12'(c);
					end
					default: smp = 12'($urandom_range(0, 4095));
				endcase
				st = ($urandom_range(0, 3) != 0);
				send_beat(smp, st, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (fault_count == 0 && pending_levels.size() == 0)
			$display("ambient_light_backlight_dimmer_unit verification clean");
		else
			$display("ambient_light_backlight_dimmer_unit verification failed");
		$finish;
	end

endmodule
